FILE: rtl/r4bcsa_pkg.sv
// ============================================================================
// Radix-4 Booth carry-save step package
// Shared types, widths and Booth selection codes for the step core and its
// round cells.
// ============================================================================
package r4bcsa_pkg;

   // Number of Booth rounds (one cell each) applied to every request.
   localparam int ROUNDS_PER_ITEM = 4;

   localparam int WORD_W  = 32;
   localparam int ACC_W   = 2 * WORD_W;
   localparam int GROUP_W = 2;

   // Width of a cell's position in the chain.
   localparam int ROUND_W = (ROUNDS_PER_ITEM > 1) ? $clog2(ROUNDS_PER_ITEM) : 1;

   // Width of the multiplicand weight shift; it holds the largest
   // shift 2*(4*ROUNDS_PER_ITEM - 1) + 1.
   localparam int SHIFT_W = $clog2(8 * ROUNDS_PER_ITEM);

   // Booth selection codes: {booth carry, multiplier bit 1, multiplier bit 0}.
   localparam logic [2:0] SEL_ZERO_A = 3'b000;
   localparam logic [2:0] SEL_POS1_A = 3'b001;
   localparam logic [2:0] SEL_NEG2   = 3'b010;
   localparam logic [2:0] SEL_NEG1_A = 3'b011;
   localparam logic [2:0] SEL_POS1_B = 3'b100;
   localparam logic [2:0] SEL_POS2   = 3'b101;
   localparam logic [2:0] SEL_NEG1_B = 3'b110;
   localparam logic [2:0] SEL_ZERO_B = 3'b111;

   typedef struct packed {
      logic [WORD_W-1:0]  sum_high;
      logic [WORD_W-1:0]  sum_low;
      logic [WORD_W-1:0]  carry_high;
      logic [WORD_W-1:0]  carry_low;
      logic [WORD_W-1:0]  multiplicand;
      logic [GROUP_W-1:0] round_group;
      logic               booth_carry_in;
      logic [WORD_W-1:0]  multiplier_bits;
      logic               signed_mode;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] new_sum_high;
      logic [WORD_W-1:0] new_sum_low;
      logic [WORD_W-1:0] new_carry_high;
      logic [WORD_W-1:0] new_carry_low;
      logic              booth_carry_out;
      logic [WORD_W-1:0] multiplier_rest;
   } rsp_type;

   // Working state handed from one round cell to the next.
   typedef struct packed {
      logic [ACC_W-1:0]   sum;
      logic [ACC_W-1:0]   car;
      logic [WORD_W-1:0]  mcand;
      logic [GROUP_W-1:0] group;
      logic               booth_carry;
      logic [WORD_W-1:0]  mul;
      logic               sgn;
   } stage_type;

endpackage

FILE: rtl/radix4_booth_csa_step_core.sv
// ============================================================================
// Radix-4 Booth carry-save multiplier step
// Runs a group of radix-4 Booth rounds on a 64-bit carry-save accumulator,
// one round per cell in a registered chain of cells.
// ============================================================================
//
//   Channel   Ports                  Handshake
//   --------  ---------------------  -----------------------------------------
//   request   start, busy, req_data  taken at a clock edge with start && !busy
//   response  rsp_valid, rsp_data    one-cycle strobe, cannot be held off
//
// Each request passes through ROUNDS_PER_ITEM round cells, one register
// stage per cell, and its response is read from the last cell's register. A
// new request can be taken in every cycle; the chain has no feedback, so
// busy stays low. A synchronous reset clears the valid bits of the chain
// and drops any request still in flight.
// ============================================================================
module radix4_booth_csa_step_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  r4bcsa_pkg::req_type req_data,
   output logic                rsp_valid,
   output r4bcsa_pkg::rsp_type rsp_data
);
   import r4bcsa_pkg::*;

   // Stage 0 is the incoming request; stage k is the output of cell k-1.
   logic      chain_valid [ROUNDS_PER_ITEM+1];
   stage_type chain_stage [ROUNDS_PER_ITEM+1];

   // The chain is fully pipelined, so the request side never waits.
   assign busy = 1'b0;

   assign chain_valid[0]             = start && !busy;
   assign chain_stage[0].sum         = {req_data.sum_high, req_data.sum_low};
   assign chain_stage[0].car         = {req_data.carry_high, req_data.carry_low};
   assign chain_stage[0].mcand       = req_data.multiplicand;
   assign chain_stage[0].group       = req_data.round_group;
   assign chain_stage[0].booth_carry = req_data.booth_carry_in;
   assign chain_stage[0].mul         = req_data.multiplier_bits;
   assign chain_stage[0].sgn         = req_data.signed_mode;

   // Each cell knows its place in the chain, which sets the weight of its
   // Booth digit within the round group.
   for (genvar gi = 0; gi < ROUNDS_PER_ITEM; gi++) begin : g_cell
      r4bcsa_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .round_index (ROUND_W'(gi)),
         .in_valid    (chain_valid[gi]),
         .in_stage    (chain_stage[gi]),
         .out_valid   (chain_valid[gi+1]),
         .out_stage   (chain_stage[gi+1])
      );
   end

   // The last cell's register is the response register.
   assign rsp_valid                = chain_valid[ROUNDS_PER_ITEM];
   assign rsp_data.new_sum_high    = chain_stage[ROUNDS_PER_ITEM].sum[ACC_W-1:WORD_W];
   assign rsp_data.new_sum_low     = chain_stage[ROUNDS_PER_ITEM].sum[WORD_W-1:0];
   assign rsp_data.new_carry_high  = chain_stage[ROUNDS_PER_ITEM].car[ACC_W-1:WORD_W];
   assign rsp_data.new_carry_low   = chain_stage[ROUNDS_PER_ITEM].car[WORD_W-1:0];
   assign rsp_data.booth_carry_out = chain_stage[ROUNDS_PER_ITEM].booth_carry;
   assign rsp_data.multiplier_rest = chain_stage[ROUNDS_PER_ITEM].mul;

   // A response only ever follows a request taken into the chain earlier.
   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, ROUNDS_PER_ITEM))
      else $error("response without a matching request");

   // Every request taken produces a response.
   a_req_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##ROUNDS_PER_ITEM rsp_valid)
      else $error("request lost in the round chain");

   // The remaining multiplier is the request's multiplier shifted by two
   // bits per round.
   a_mul_shift: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.multiplier_rest ==
                    ($past(req_data.multiplier_bits, ROUNDS_PER_ITEM)
                     >> (2 * ROUNDS_PER_ITEM)))
      else $error("multiplier rest does not match the request");

   // The outgoing Booth carry is the high bit of the last digit consumed.
   a_booth_carry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.booth_carry_out ==
                    $past(req_data.multiplier_bits[2*ROUNDS_PER_ITEM-1], ROUNDS_PER_ITEM))
      else $error("Booth carry out does not match the request");

endmodule

FILE: rtl/r4bcsa_cell.sv
// ============================================================================
// Radix-4 Booth round cell
// Applies one Booth round to the working state and registers the result for
// the next cell in the chain.
// ============================================================================
module r4bcsa_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [r4bcsa_pkg::ROUND_W-1:0] round_index,
   input  logic                          in_valid,
   input  r4bcsa_pkg::stage_type         in_stage,
   output logic                          out_valid,
   output r4bcsa_pkg::stage_type         out_stage
);
   import r4bcsa_pkg::*;

   logic                 valid_ff;
   stage_type            stage_ff;
   stage_type            stage_in;

   logic [ACC_W-1:0]     mcand_ext;
   logic [SHIFT_W-1:0]   shift_base;
   logic [2:0]           sel;
   logic [ACC_W-1:0]     opnd;
   logic [ACC_W-1:0]     opnd_adj;
   logic [ACC_W-1:0]     car_adj;
   logic [ACC_W-1:0]     part_sum;
   logic [ACC_W-1:0]     new_car;
   logic                 neg;

   assign mcand_ext = in_stage.sgn
                      ? {{WORD_W{in_stage.mcand[WORD_W-1]}}, in_stage.mcand}
                      : {{WORD_W{1'b0}}, in_stage.mcand};

   // Round n = group*ROUNDS_PER_ITEM + index weighs the digit by 4^n.
   assign shift_base = SHIFT_W'(in_stage.group) * SHIFT_W'(2 * ROUNDS_PER_ITEM)
                     + (SHIFT_W'(round_index) << 1);

   assign sel = {in_stage.booth_carry, in_stage.mul[1:0]};

   always_comb begin
      opnd = '0;
      neg  = 1'b0;
      unique case (sel)
         SEL_POS1_A, SEL_POS1_B: begin
            opnd = mcand_ext << shift_base;
         end
         SEL_POS2: begin
            opnd = mcand_ext << (shift_base + SHIFT_W'(1));
         end
         SEL_NEG2: begin
            opnd = mcand_ext << (shift_base + SHIFT_W'(1));
            neg  = 1'b1;
         end
         SEL_NEG1_A, SEL_NEG1_B: begin
            opnd = mcand_ext << shift_base;
            neg  = 1'b1;
         end
         SEL_ZERO_A, SEL_ZERO_B: begin
            opnd = '0;
         end
         default: begin
            opnd = '0;
         end
      endcase
   end

   // Negation is inversion plus a one ORed into carry bit 0.
   assign opnd_adj = neg ? ~opnd : opnd;
   assign car_adj  = neg ? (in_stage.car | ACC_W'(1)) : in_stage.car;

   assign part_sum = in_stage.sum ^ opnd_adj;
   assign new_car  = (opnd_adj & ~part_sum) | (car_adj & part_sum);

   always_comb begin
      stage_in             = in_stage;
      stage_in.sum         = part_sum ^ car_adj;
      stage_in.car         = new_car << 1;
      stage_in.booth_carry = in_stage.mul[1];
      stage_in.mul         = in_stage.mul >> 2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

FILE: tb/tb_top.sv
// ============================================================================
// Radix-4 Booth carry-save step testbench
// Drives requests into the step core with random idle gaps. Each request's
// response is predicted by a behavioral model of the four Booth rounds. Every
// response strobe is compared field by field with the oldest prediction.
// ============================================================================
module tb_top;
   import r4bcsa_pkg::*;

   // Cycles without any request or response before the run is abandoned.
   // The longest legal quiet stretch is a sender gap plus the pipeline, so
   // this is far above any correct run.
   localparam int STALL_LIMIT  = 400;
   // Cycles to keep watching after the last expected response has arrived.
   // This catches stray strobes out of the pipeline.
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_ITEMS = 1350;

   // -------------------------------------------------------------------------
   // Response predictor and in-order store of expected responses.
   // -------------------------------------------------------------------------
   class booth_step_checker;
      rsp_type pending_steps[$];
      int      mismatch_count = 0;

      // Runs the Booth rounds of one request on the carry-save accumulator.
      function rsp_type booth_step(req_type r);
         logic [ACC_W-1:0]  acc_sum;
         logic [ACC_W-1:0]  acc_car;
         logic [ACC_W-1:0]  m_ext;
         logic [ACC_W-1:0]  addend;
         logic [ACC_W-1:0]  half_sum;
         logic [WORD_W-1:0] mul;
         logic [2:0]        sel;
         logic              bc;
         logic              neg;
         int                pos;
         rsp_type           res;
         acc_sum = {r.sum_high, r.sum_low};
         acc_car = {r.carry_high, r.carry_low};
         m_ext   = r.signed_mode ? {{WORD_W{r.multiplicand[WORD_W-1]}}, r.multiplicand}
                                 : {{WORD_W{1'b0}}, r.multiplicand};
         mul     = r.multiplier_bits;
         bc      = r.booth_carry_in;
         for (int i = 0; i < ROUNDS_PER_ITEM; i++) begin
            // Weight of this round's digit is 4^n with n counted across groups.
            pos    = 2 * (int'(r.round_group) * ROUNDS_PER_ITEM + i);
            sel    = {bc, mul[1:0]};
            addend = '0;
            neg    = 1'b0;
            case (sel)
               SEL_POS1_A, SEL_POS1_B: begin
                  addend = (pos >= ACC_W) ? '0 : m_ext << pos;
               end
               SEL_POS2: begin
                  addend = (pos + 1 >= ACC_W) ? '0 : m_ext << (pos + 1);
               end
               SEL_NEG2: begin
                  addend = (pos + 1 >= ACC_W) ? '0 : m_ext << (pos + 1);
                  neg    = 1'b1;
               end
               SEL_NEG1_A, SEL_NEG1_B: begin
                  addend = (pos >= ACC_W) ? '0 : m_ext << pos;
                  neg    = 1'b1;
               end
               default: begin
                  addend = '0;
               end
            endcase
            // Subtraction is inversion plus a one ORed into the carry word.
            if (neg) begin
               addend     = ~addend;
               acc_car[0] = 1'b1;
            end
            half_sum = acc_sum ^ addend;
            acc_sum  = half_sum ^ acc_car;
            acc_car  = (addend & ~half_sum) | (acc_car & half_sum);
            acc_car  = acc_car << 1;
            bc       = sel[1];
            mul      = mul >> 2;
         end
         res.new_sum_high    = acc_sum[ACC_W-1:WORD_W];
         res.new_sum_low     = acc_sum[WORD_W-1:0];
         res.new_carry_high  = acc_car[ACC_W-1:WORD_W];
         res.new_carry_low   = acc_car[WORD_W-1:0];
         res.booth_carry_out = bc;
         res.multiplier_rest = mul;
         return res;
      endfunction

      function void note_request(req_type r);
         pending_steps.push_back(booth_step(r));
      endfunction

      function void compare_field(string name, logic [WORD_W-1:0] want,
                                  logic [WORD_W-1:0] got);
         if (got !== want) begin
            $error("%s: expected %h, actual %h", name, want, got);
            mismatch_count++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (pending_steps.size() == 0) begin
            $error("response: expected none, actual %h", got);
            mismatch_count++;
            return;
         end
         want = pending_steps.pop_front();
         compare_field("new_sum_high", want.new_sum_high, got.new_sum_high);
         compare_field("new_sum_low", want.new_sum_low, got.new_sum_low);
         compare_field("new_carry_high", want.new_carry_high, got.new_carry_high);
         compare_field("new_carry_low", want.new_carry_low, got.new_carry_low);
         compare_field("booth_carry_out", WORD_W'(want.booth_carry_out),
                       WORD_W'(got.booth_carry_out));
         compare_field("multiplier_rest", want.multiplier_rest, got.multiplier_rest);
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and the block under test.
   // -------------------------------------------------------------------------
   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   booth_step_checker step_chk = new();
   int  items_sent   = 0;
   int  stall_cycles = 0;
   // When set, the sender issues back-to-back requests with no idle gaps.
   logic idle_off = 1'b0;

   always #6 clock = ~clock;

   radix4_booth_csa_step_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // -------------------------------------------------------------------------
   // Monitor. All inputs change through nonblocking assignments at the clock
   // edge, so the values read here are the ones the block saw at that edge.
   // A request is taken when start is high and busy is low; a response is
   // taken whenever the strobe is high.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            step_chk.check_response(rsp_data);
         end
         if (start && !busy) begin
            step_chk.note_request(req_data);
         end
      end
   end

   // Watchdog: a run that goes quiet for too long has hung.
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles == STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers.
   // -------------------------------------------------------------------------

   // Presents one request after a random idle gap and holds it until taken.
   // Start is written at most once per clock edge, so a back-to-back request
   // simply keeps it high.
   task automatic send_request(input req_type r);
      int gap;
      if ($urandom_range(0, 39) == 0) begin
         idle_off = !idle_off;
      end
      gap = idle_off ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   function automatic req_type make_req(logic [31:0] sh, logic [31:0] sl,
                                        logic [31:0] ch, logic [31:0] cl,
                                        logic [31:0] m, logic [1:0] grp,
                                        logic bc, logic [31:0] mul, logic sgn);
      req_type r;
      r.sum_high        = sh;
      r.sum_low         = sl;
      r.carry_high      = ch;
      r.carry_low       = cl;
      r.multiplicand    = m;
      r.round_group     = grp;
      r.booth_carry_in  = bc;
      r.multiplier_bits = mul;
      r.signed_mode     = sgn;
      return r;
   endfunction

   // Random word with extra weight on the values that stress sign and carry.
   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 9))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         4: return 32'h0000_0001;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type rand_req();
      return make_req(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                      2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                      rand_word(), 1'($urandom_range(0, 1)));
   endfunction

   // A whole 32x32 product: four groups, each request seeded from the
   // predicted response of the one before. Now and then a link is broken
   // by a wrong group index or a flipped Booth carry.
   task automatic run_product();
      req_type r;
      rsp_type p;
      r = make_req(32'h0, 32'h0, 32'h0, 32'h0, rand_word(), 2'd0, 1'b0,
                   $urandom, 1'($urandom_range(0, 1)));
      // Some products add onto an existing accumulator.
      if ($urandom_range(0, 3) == 0) begin
         r.sum_low   = $urandom;
         r.carry_low = $urandom;
      end
      for (int g = 0; g < 4; g++) begin
         r.round_group = 2'(g);
         if ($urandom_range(0, 19) == 0) begin
            r.round_group = 2'($urandom_range(0, 3));
         end
         if ($urandom_range(0, 19) == 0) begin
            r.booth_carry_in = ~r.booth_carry_in;
         end
         send_request(r);
         p = step_chk.booth_step(r);
         r.sum_high        = p.new_sum_high;
         r.sum_low         = p.new_sum_low;
         r.carry_high      = p.new_carry_high;
         r.carry_low       = p.new_carry_low;
         r.booth_carry_in  = p.booth_carry_out;
         r.multiplier_bits = p.multiplier_rest;
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence.
   // -------------------------------------------------------------------------
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed requests. A multiplier of 0x39 with no incoming Booth carry
      // walks through +M, -2M, the all-ones zero digit and the carry-only +M.
      // A multiplier of 0x2D with an incoming carry walks through +2M and both
      // forms of -M. The all-zero request covers the plain zero digit.
      send_request(make_req('0, '0, '0, '0, '0, 2'd0, 1'b0, '0, 1'b0));
      send_request(make_req('1, '1, '1, '1, '1, 2'd3, 1'b1, '1, 1'b1));
      send_request(make_req('0, '0, '0, '0, 32'h1234_5678, 2'd0, 1'b0, 32'h39, 1'b0));
      send_request(make_req('0, '0, '0, '0, 32'h1234_5678, 2'd0, 1'b1, 32'h2D, 1'b0));
      send_request(make_req('0, '0, '0, '0, 32'h8000_0000, 2'd0, 1'b0, 32'h39, 1'b1));
      send_request(make_req('0, '0, '0, '0, 32'h8000_0000, 2'd0, 1'b0, 32'h39, 1'b0));
      send_request(make_req('0, '0, '0, '0, 32'hFFFF_FFFF, 2'd1, 1'b1, 32'h2D, 1'b1));
      send_request(make_req('0, '0, '0, '0, 32'hFFFF_FFFF, 2'd2, 1'b0, 32'h39, 1'b1));
      // Top group: the weighted 2M runs past bit 63 and loses its top bits.
      send_request(make_req('0, '0, '0, '0, 32'hFFFF_FFFF, 2'd3, 1'b1, 32'h2D, 1'b1));
      send_request(make_req('0, '0, '0, '0, 32'hC000_0001, 2'd3, 1'b0, 32'h39, 1'b0));
      // A negative digit while carry bit 0 is already set: the injected one
      // is absorbed rather than added.
      send_request(make_req('0, '0, '0, 32'h0000_0001, 32'h0000_0005, 2'd0, 1'b0,
                            32'h3, 1'b0));
      send_request(make_req(32'hDEAD_BEEF, 32'h0123_4567, '0, 32'h0000_0001,
                            32'h8000_0001, 2'd2, 1'b0, 32'h3, 1'b1));
      // Zero digits only: the accumulator is just recoded into carry-save form.
      send_request(make_req(32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hFFFF_0000, 32'h0F0F_F0F0,
                            32'h1357_9BDF, 2'd1, 1'b0, 32'h0, 1'b0));
      send_request(make_req(32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h3333_CCCC, 32'hCCCC_3333,
                            '1, 2'd2, 1'b1, '1, 1'b1));
      send_request(make_req('0, '0, '0, '0, 32'h7FFF_FFFF, 2'd1, 1'b0, 32'hAAAA_AAAA, 1'b1));
      send_request(make_req('0, '0, '0, '0, 32'h0000_0001, 2'd3, 1'b0, 32'h5555_5555, 1'b0));
      send_request(make_req('1, '0, '0, '1, 32'h8000_0000, 2'd3, 1'b1, 32'hFFFF_FFFF, 1'b1));
      send_request(make_req('0, '1, '1, '0, 32'h8000_0000, 2'd1, 1'b1, 32'h8000_0000, 1'b0));

      // Random part: mostly complete products, the rest isolated requests.
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) < 6) begin
            run_product();
         end else begin
            send_request(rand_req());
         end
      end
      start <= 1'b0;

      // Let the pipeline drain, then keep watching for stray strobes.
      do @(posedge clock); while (step_chk.pending_steps.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (step_chk.mismatch_count == 0 && step_chk.pending_steps.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
